// File: src/itt_pkg.sv
`timescale 1ns / 1ps
package itt_pkg;

  localparam int SLOT_W = 6;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [7:0]        arg;
    logic [12:0]       period;
    logic [15:0]       remaining;
    logic [31:0]       due;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              append;
    logic [SLOT_W-1:0] wpos;
    entry_t            proc;
  } cell_ctrl_t;

endpackage

// File: src/itt_if.sv
`timescale 1ns / 1ps
interface itt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  arg;
  logic [15:0] delay_ms;
  logic [15:0] period_ms;
  logic [15:0] repeat_count;
  logic [4:0]  handle;
  modport source (output valid, action, arg, delay_ms, period_ms, repeat_count, handle,
                  input ready);
  modport sink (input valid, action, arg, delay_ms, period_ms, repeat_count, handle,
                output ready);
endinterface

interface itt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] slot;
  logic [7:0] fired_arg;
  logic       final_fire;
  logic       last;
  modport source (output valid, kind, slot, fired_arg, final_fire, last, input ready);
  modport sink (input valid, kind, slot, fired_arg, final_fire, last, output ready);
endinterface

// File: src/itt_cell.sv
`timescale 1ns / 1ps
module itt_cell
  import itt_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output entry_t     entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_INSERT: entry_q <= prev_i;
      CELL_SHIFT: begin
        // surviving head item re-enters at the end of the queue
        if (ctrl_i.append && ctrl_i.wpos == SLOT_W'(INDEX)) entry_q <= ctrl_i.proc;
        else entry_q <= next_i;
      end
      default: entry_q <= entry_q;
    endcase
  end

  assign entry_o = entry_q;

endmodule

// File: src/interval_timer_table.sv
`timescale 1ns / 1ps
// channel | dir | handshake         | payload
// in_i    | in  | valid/ready       | action, arg, delay_ms, period_ms, repeat_count, handle
// out_o   | out | valid/ready       | kind, slot, fired_arg, final_fire, last
// set and table-full answer in the cycle after acceptance; a clear of a valid slot walks
// the cell chain one entry per cycle; a tick with active timers walks it as well and
// then, in a flush state, sends its final held firing, if any, marked last.
// a bad clear, an unused action and a tick on an empty table end without a walk.
// a firing stalls the walk while its predecessor waits on a busy output.
// reset clears the tick counter, the slot map and the queue length.
module interval_timer_table
  import itt_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  itt_in_if.sink    in_i,
  itt_out_if.source out_o
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_e;

  state_e            state_q;
  logic [31:0]       tick_q;
  logic [SLOTS-1:0]  valid_q;
  logic [CW-1:0]     len_q, steps_q;
  logic              mode_tick_q;
  logic [SLOT_W-1:0] hd_q;
  logic              hold_v_q;
  logic [SLOT_W-1:0] hold_slot_q;
  logic [7:0]        hold_arg_q;
  logic              hold_fin_q;
  logic              out_v_q;
  logic [1:0]        out_kind_q;
  logic [4:0]        out_slot_q;
  logic [7:0]        out_arg_q;
  logic              out_fin_q;
  logic              out_last_q;

  entry_t     ent [SLOTS];
  entry_t     new_entry, head, proc;
  cell_ctrl_t ctrl;
  logic       out_free, accept, fire, retire, drop, step_ok, full, set_ok;
  logic [SLOT_W-1:0] top;
  logic [15:0] sum_ms, first_t, per_t;

  assign out_free = !out_v_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;

  // next slot sits just above the highest valid one
  always_comb begin
    top = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_q[i]) top = SLOT_W'(i + 1);
    end
  end
  assign full = valid_q[SLOTS-1];
  assign set_ok = accept && in_i.action == ACT_SET && !full;

  always_comb begin
    sum_ms  = in_i.delay_ms + in_i.period_ms;
    first_t = 16'(sum_ms + 16'd7) >> 3;
    per_t   = 16'(in_i.period_ms + 16'd7) >> 3;
    new_entry.slot      = top;
    new_entry.arg       = in_i.arg;
    new_entry.period    = per_t[12:0];
    new_entry.remaining = in_i.repeat_count;
    new_entry.due       = tick_q + 32'(first_t);
  end

  assign head   = ent[0];
  assign fire   = mode_tick_q && (tick_q >= head.due);
  assign retire = fire && head.remaining == 16'd1;
  assign drop   = mode_tick_q ? retire : (head.slot == hd_q);
  assign step_ok = (state_q == S_SCAN) && !(fire && hold_v_q && !out_free);

  always_comb begin
    proc = head;
    if (fire) begin
      proc.due = head.due + 32'(head.period);
      if (head.remaining > 16'd1) proc.remaining = head.remaining - 16'd1;
    end
    ctrl.op     = set_ok ? CELL_INSERT : (step_ok ? CELL_SHIFT : CELL_HOLD);
    ctrl.append = !drop;
    ctrl.wpos   = SLOT_W'(len_q - 1'b1);
    ctrl.proc   = proc;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = ent[g-1];
    end
    if (g == SLOTS - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_nxt
      assign next_e = ent[g+1];
    end
    itt_cell #(.INDEX(g)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (ent[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      valid_q     <= '0;
      len_q       <= '0;
      steps_q     <= '0;
      mode_tick_q <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (out_o.ready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          mode_tick_q <= 1'b0;
          if (accept) begin
            unique case (in_i.action)
              ACT_TICK: begin
                tick_q      <= tick_q + 32'd1;
                mode_tick_q <= 1'b1;
                steps_q     <= len_q;
                if (len_q != '0) state_q <= S_SCAN;
              end
              ACT_SET: begin
                out_v_q    <= 1'b1;
                out_arg_q  <= '0;
                out_fin_q  <= 1'b0;
                out_last_q <= 1'b1;
                if (full) begin
                  out_kind_q <= KIND_FULL;
                  out_slot_q <= '0;
                end else begin
                  out_kind_q <= KIND_SET;
                  out_slot_q <= top[4:0];
                  valid_q[top[IW-1:0]] <= 1'b1;
                  len_q <= len_q + 1'b1;
                end
              end
              ACT_CLEAR: begin
                hd_q <= SLOT_W'(in_i.handle);
                if (int'(in_i.handle) < SLOTS && valid_q[IW'(in_i.handle)]) begin
                  valid_q[IW'(in_i.handle)] <= 1'b0;
                  steps_q <= len_q;
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (step_ok) begin
            if (drop) len_q <= len_q - 1'b1;
            if (fire) begin
              // previous firing goes out now that a later one exists
              if (hold_v_q) begin
                out_v_q    <= 1'b1;
                out_kind_q <= KIND_FIRED;
                out_slot_q <= hold_slot_q[4:0];
                out_arg_q  <= hold_arg_q;
                out_fin_q  <= hold_fin_q;
                out_last_q <= 1'b0;
              end
              hold_v_q    <= 1'b1;
              hold_slot_q <= head.slot;
              hold_arg_q  <= head.arg;
              hold_fin_q  <= retire;
              if (retire) valid_q[head.slot[IW-1:0]] <= 1'b0;
            end
            steps_q <= steps_q - 1'b1;
            if (steps_q == CW'(1)) state_q <= mode_tick_q ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!hold_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_v_q    <= 1'b1;
            out_kind_q <= KIND_FIRED;
            out_slot_q <= hold_slot_q[4:0];
            out_arg_q  <= hold_arg_q;
            out_fin_q  <= hold_fin_q;
            out_last_q <= 1'b1;
            hold_v_q   <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.slot       = out_slot_q;
  assign out_o.fired_arg  = out_arg_q;
  assign out_o.final_fire = out_fin_q;
  assign out_o.last       = out_last_q;

endmodule

// File: tb/sv/interval_timer_table_tb.sv
`timescale 1ns / 1ps
module interval_timer_table_tb;
  import itt_pkg::*;

  localparam int NSLOT = 32;
  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_ITEMS = 80;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  arg;
    logic [15:0] delay_ms;
    logic [15:0] period_ms;
    logic [15:0] repeat_count;
    logic [4:0]  handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] slot;
    logic [7:0] fired_arg;
    logic       final_fire;
    logic       last;
  } event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itt_in_if  cmd_bus ();
  itt_out_if evt_bus ();

  interval_timer_table #(.SLOTS(NSLOT)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_bus),
    .out_o (evt_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timer table mirror
  logic [31:0] now_ticks;
  logic        live[NSLOT];
  logic [7:0]  t_arg[NSLOT];
  logic [15:0] t_period[NSLOT];
  logic [15:0] t_left[NSLOT];
  logic [31:0] t_due[NSLOT];
  logic [4:0]  newest_first[NSLOT];
  int          live_count;

  cmd_t   cmd_q[$];
  event_t due_events[$];
  int     events_predicted = 0;
  int     fires_predicted = 0;
  int     fulls_predicted = 0;
  int     items_sent = 0;
  int     mismatches = 0;
  int     events_seen = 0;
  int     cycles = 0;

  task automatic drop_timer(input int s);
    int j;
    j = 0;
    for (int i = 0; i < live_count; i++)
      if (newest_first[i] != s[4:0]) begin
        newest_first[j] = newest_first[i];
        j++;
      end
    live_count = j;
    live[s] = 1'b0;
  endtask

  task automatic apply_cmd(input cmd_t c);
    int          top;
    logic [15:0] sum;
    logic [15:0] first;
    logic [4:0]  snap[NSLOT];
    int          n;
    int          s;
    event_t      e;
    event_t      burst[$];
    case (c.action)
      ACT_SET: begin
        top = NSLOT;
        while (top > 0 && !live[top-1]) top--;
        e = '0;
        e.last = 1'b1;
        if (top >= NSLOT) begin
          e.kind = KIND_FULL;
          fulls_predicted++;
        end else begin
          sum = c.delay_ms + c.period_ms;
          first = sum + 16'd7;
          live[top] = 1'b1;
          t_arg[top] = c.arg;
          t_period[top] = 16'(c.period_ms + 16'd7) >> 3;
          t_left[top] = c.repeat_count;
          t_due[top] = now_ticks + 32'(first >> 3);
          for (int i = live_count; i > 0; i--) newest_first[i] = newest_first[i-1];
          newest_first[0] = top[4:0];
          live_count++;
          e.kind = KIND_SET;
          e.slot = top[4:0];
        end
        due_events.push_back(e);
        events_predicted++;
      end
      ACT_CLEAR: begin
        if (live[c.handle]) drop_timer(c.handle);
      end
      ACT_TICK: begin
        n = live_count;
        for (int i = 0; i < n; i++) snap[i] = newest_first[i];
        now_ticks++;
        for (int i = 0; i < n; i++) begin
          s = snap[i];
          if (live[s] && now_ticks >= t_due[s]) begin
            e.kind = KIND_FIRED;
            e.slot = s[4:0];
            e.fired_arg = t_arg[s];
            e.final_fire = (t_left[s] == 16'd1);
            e.last = 1'b0;
            t_due[s] = t_due[s] + 32'(t_period[s]);
            burst.push_back(e);
            if (e.final_fire) drop_timer(s);
            else if (t_left[s] != 16'd0) t_left[s]--;
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) due_events.push_back(burst[i]);
        events_predicted += burst.size();
        fires_predicted += burst.size();
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // stretches of back-to-back traffic alternate with gappy ones
  logic busy_run = 1'b0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) busy_run <= ($urandom_range(3) == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, due_events.size());
      $display("Verification failed");
      $finish;
    end
  end

  // driver
  logic cmd_taken;
  int   send_gap = 0;
  always @(posedge clk) begin
    cmd_taken <= cmd_bus.valid && cmd_bus.ready;
    if (rst_n && cmd_bus.valid && cmd_bus.ready) begin
      apply_cmd({cmd_bus.action, cmd_bus.arg, cmd_bus.delay_ms, cmd_bus.period_ms,
                 cmd_bus.repeat_count, cmd_bus.handle});
      items_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!cmd_bus.valid || cmd_taken)) begin
      if (send_gap > 0 || cmd_q.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        cmd_bus.valid <= 1'b0;
      end else begin
        {cmd_bus.action, cmd_bus.arg, cmd_bus.delay_ms, cmd_bus.period_ms,
         cmd_bus.repeat_count, cmd_bus.handle} <= cmd_q.pop_front();
        cmd_bus.valid <= 1'b1;
        send_gap <= busy_run ? 0 : pick_gap();
      end
    end
  end

  // monitor
  int stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      stall <= stall - 1;
      evt_bus.ready <= 1'b0;
    end else begin
      evt_bus.ready <= 1'b1;
      stall <= busy_run ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    event_t got;
    event_t want;
    if (rst_n && evt_bus.valid && evt_bus.ready) begin
      got = {evt_bus.kind, evt_bus.slot, evt_bus.fired_arg, evt_bus.final_fire,
             evt_bus.last};
      events_seen++;
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: kind %0d slot %0d arg %02h final %0d last %0d",
                   got.kind, got.slot, got.fired_arg, got.final_fire, got.last);
      end else begin
        want = due_events.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at item %0d: exp kind %0d slot %0d arg %02h fin %0d last %0d, got kind %0d slot %0d arg %02h fin %0d last %0d",
                     events_seen, want.kind, want.slot, want.fired_arg, want.final_fire,
                     want.last, got.kind, got.slot, got.fired_arg, got.final_fire,
                     got.last);
        end
      end
    end
  end

  function automatic cmd_t mk(input logic [1:0] act, input logic [7:0] a,
                              input logic [15:0] d, input logic [15:0] p,
                              input logic [15:0] r, input logic [4:0] h);
    cmd_t c;
    c.action = act;
    c.arg = a;
    c.delay_ms = d;
    c.period_ms = p;
    c.repeat_count = r;
    c.handle = h;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    c = $urandom;
    r = $urandom_range(99);
    if (r < 40) c.action = ACT_SET;
    else if (r < 85) c.action = ACT_TICK;
    else if (r < 96) c.action = ACT_CLEAR;
    else c.action = ACT_IDLE;
    // mostly short timers so that firings keep coming
    if ($urandom_range(9) != 0) c.delay_ms = $urandom_range(40);
    if ($urandom_range(9) != 0) c.period_ms = $urandom_range(48);
    if ($urandom_range(9) != 0) c.repeat_count = $urandom_range(5);
    if ($urandom_range(3) != 0) c.handle = $urandom_range(7);
    return c;
  endfunction

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.action = ACT_TICK;
    cmd_bus.arg = '0;
    cmd_bus.delay_ms = '0;
    cmd_bus.period_ms = '0;
    cmd_bus.repeat_count = '0;
    cmd_bus.handle = '0;
    evt_bus.ready = 1'b0;
    now_ticks = '0;
    live_count = 0;
    foreach (live[i]) live[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: fire-once, wrapped period, forever timers, bad clears, unused action
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'hff, 16'd0, 16'd0, 16'd1, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'h55, 16'hffff, 16'hffff, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'haa, 16'd16, 16'd8, 16'd3, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'h00, 16'hfff8, 16'h0007, 16'hffff, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'h3c, 16'd0, 16'h8000, 16'h8000, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_CLEAR, 8'h00, 16'd0, 16'd0, 16'd0, 5'd31));
    cmd_q.push_back(mk(ACT_CLEAR, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_IDLE, 8'hff, 16'hffff, 16'hffff, 16'hffff, 5'd31));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_CLEAR, 8'h00, 16'd0, 16'd0, 16'd0, 5'd1));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_SET, 8'h81, 16'd8, 16'd8, 16'd2, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_TICK, 8'h00, 16'd0, 16'd0, 16'd0, 5'd0));
    cmd_q.push_back(mk(ACT_CLEAR, 8'h00, 16'd0, 16'd0, 16'd0, 5'd3));

    // random mix of sets, ticks, clears and unused actions
    for (int i = 0; i < RAND_ITEMS; i++) begin
      cmd_q.push_back(rand_cmd());
      while (cmd_q.size() > 3) @(negedge clk);
    end

    while (cmd_q.size() > 0 || cmd_bus.valid) @(negedge clk);
    while (due_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_events.size() > 0) begin
      mismatches++;
      $display("%0d expected items never arrived", due_events.size());
    end

    $display("sent %0d commands over %0d ticks; checked %0d of %0d items (%0d firings, %0d refusals)",
             items_sent, now_ticks, events_seen, events_predicted, fires_predicted,
             fulls_predicted);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
